/* hdl/pph_pkg.sv */
// ----------------------------------------------------------------------------
// pph_pkg
// Shared types and constants for the polygon point hit test block.
// ----------------------------------------------------------------------------
package pph_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_QUERY_X  = 2'd0;
    localparam logic [1:0] CFG_QUERY_Y  = 2'd1;
    localparam logic [1:0] CFG_MARGIN   = 2'd2;
    localparam logic [1:0] CFG_CLOSED   = 2'd3;

    localparam int MARGIN_W     = 20;
    localparam int EDGE_INDEX_W = 12;
    localparam int QUEUE_DEPTH  = 4;

    // Control flags that travel with one edge job through the queue.
    typedef struct packed {
        logic seg_ok;     // run the segment distance test on this edge
        logic cross_pre;  // x span condition of the crossing test holds
        logic emit;       // closing edge or single-vertex shape: deliver the shape result afterwards
        logic inside_en;  // shape is closed and has at least three vertices
    } job_flags_t;

    localparam int JOB_FLAGS_W = $bits(job_flags_t);

endpackage

/* hdl/polygon_point_hit_test.sv */
// ----------------------------------------------------------------------------
// polygon_point_hit_test
// Hit test of a query point against a streamed polyline or polygon: nearest
// segment within a margin and even-odd inside test, one result per shape.
// ----------------------------------------------------------------------------
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  config  | cfg_we, cfg_index, cfg_wdata            | in
//  vertex  | s_valid/s_ready, s_vertex_x/y, s_last.. | in
//  result  | m_valid/m_ready, m_near_edge .. m_hit   | out
//
// Each edge passes through the shared limb multiplier, either for the
// crossing test alone or also for the full distance and nearest
// segment comparison; the multiplier is the limiting unit.
// The last vertex adds a closing edge. A four-entry job queue lets the front
// keep taking vertices while the back end works. Synchronous active-low
// reset clears all shape state; the result register holds until taken.
// ----------------------------------------------------------------------------
module polygon_point_hit_test #(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_BITS   = 24,
    localparam int CFG_W = (COORD_BITS > pph_pkg::MARGIN_W) ? COORD_BITS : pph_pkg::MARGIN_W
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [CFG_W-1:0]                  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COORD_BITS-1:0]      s_vertex_x,
    input  logic signed [COORD_BITS-1:0]      s_vertex_y,
    input  logic                              s_last_vertex,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_near_edge,
    output logic [pph_pkg::EDGE_INDEX_W-1:0]  m_edge_index,
    output logic                              m_inside_res,
    output logic                              m_hit
);
    import pph_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int JOB_W = JOB_FLAGS_W + CNT_W + 8 * (COORD_BITS + 1);

    logic [MARGIN_W-1:0] margin;
    logic                job_push, job_full, job_pop, job_empty;
    logic [JOB_W-1:0]    job_in, job_out;

    // Vertex intake and edge classification.
    pph_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_vertex_x    (s_vertex_x),
        .s_vertex_y    (s_vertex_y),
        .s_last_vertex (s_last_vertex),
        .margin        (margin),
        .job_push      (job_push),
        .job_data      (job_in),
        .job_full      (job_full)
    );

    // Edge job queue.
    pph_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    // Arithmetic and result delivery.
    pph_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .margin       (margin),
        .job_empty    (job_empty),
        .job_data     (job_out),
        .job_pop      (job_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_near_edge  (m_near_edge),
        .m_edge_index (m_edge_index),
        .m_inside_res (m_inside_res),
        .m_hit        (m_hit)
    );

endmodule

/* hdl/pph_fifo.sv */
// ----------------------------------------------------------------------------
// pph_fifo
// Short queue of edge jobs between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module pph_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import pph_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/pph_front.sv */
// ----------------------------------------------------------------------------
// pph_front
// Holds the configuration, accepts vertices, tracks the shape and turns each
// edge into a job of coordinate differences for the back end.
// ----------------------------------------------------------------------------
module pph_front #(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_BITS   = 24,
    localparam int CFG_W  = (COORD_BITS > pph_pkg::MARGIN_W) ? COORD_BITS : pph_pkg::MARGIN_W,
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1),
    localparam int D_W    = COORD_BITS + 1,
    localparam int JOB_W  = pph_pkg::JOB_FLAGS_W + CNT_W + 8 * D_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [CFG_W-1:0]              cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_vertex_x,
    input  logic signed [COORD_BITS-1:0]  s_vertex_y,
    input  logic                          s_last_vertex,
    output logic [pph_pkg::MARGIN_W-1:0]  margin,
    output logic                          job_push,
    output logic [JOB_W-1:0]              job_data,
    input  logic                          job_full
);
    import pph_pkg::*;

    logic signed [COORD_BITS-1:0] query_x_reg, query_y_reg;
    logic [MARGIN_W-1:0]          margin_reg;
    logic                         closed_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         pend_close_reg;

    logic                         accept;
    logic                         first_vtx;
    logic signed [COORD_BITS-1:0] eo_x, eo_y, en_x, en_y;
    logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
    logic signed [D_W-1:0]        dx, dy, ux, uy, cy1, cdx, cdy, cx1;
    logic [CNT_W-1:0]             seg;
    job_flags_t                   flags;

    assign margin    = margin_reg;
    assign s_ready   = !job_full && !pend_close_reg;
    assign accept    = s_valid && s_ready;
    assign first_vtx = (count_reg == '0);
    assign seg       = count_reg - 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_x_reg <= '0;
            query_y_reg <= '0;
            margin_reg  <= '0;
            closed_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_QUERY_X: query_x_reg <= cfg_wdata[COORD_BITS-1:0];
                CFG_QUERY_Y: query_y_reg <= cfg_wdata[COORD_BITS-1:0];
                CFG_MARGIN:  margin_reg  <= cfg_wdata[MARGIN_W-1:0];
                CFG_CLOSED:  closed_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Edge end points: an ordinary edge runs from the previous vertex to the
    // new one, the closing edge from the last vertex back to the first.
    always_comb begin
        if (!pend_close_reg && first_vtx) begin
            eo_x = s_vertex_x;
            eo_y = s_vertex_y;
        end else begin
            eo_x = prev_x_reg;
            eo_y = prev_y_reg;
        end
        if (pend_close_reg) begin
            en_x = first_x_reg;
            en_y = first_y_reg;
        end else begin
            en_x = s_vertex_x;
            en_y = s_vertex_y;
        end
    end

    // Differences for the segment and crossing products.
    always_comb begin
        if (en_x > eo_x) begin
            x1 = eo_x; y1 = eo_y; x2 = en_x; y2 = en_y;
        end else begin
            x1 = en_x; y1 = en_y; x2 = eo_x; y2 = eo_y;
        end
        dx  = D_W'(en_x) - D_W'(eo_x);
        dy  = D_W'(en_y) - D_W'(eo_y);
        ux  = D_W'(query_x_reg) - D_W'(eo_x);
        uy  = D_W'(query_y_reg) - D_W'(eo_y);
        cy1 = D_W'(query_y_reg) - D_W'(y1);
        cdx = D_W'(x2) - D_W'(x1);
        cdy = D_W'(y2) - D_W'(y1);
        cx1 = D_W'(query_x_reg) - D_W'(x1);

        flags.seg_ok    = !pend_close_reg && !first_vtx &&
                          (count_reg < CNT_W'(MAX_VERTICES));
        flags.cross_pre = (en_x < query_x_reg) == (query_x_reg <= eo_x);
        flags.emit      = pend_close_reg || first_vtx;
        flags.inside_en = pend_close_reg && closed_reg && (count_reg >= CNT_W'(3));
    end

    assign job_data = {flags, seg, cx1, cdy, cdx, cy1, uy, ux, dy, dx};
    assign job_push = pend_close_reg ? !job_full
                                     : (accept && (!first_vtx || s_last_vertex));

    // Saturating vertex count.
    always_comb begin
        count_next = count_reg;
        if (count_reg < CNT_W'(MAX_VERTICES)) begin
            count_next = count_reg + 1'b1;
        end
    end

    // Shape tracking.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            pend_close_reg <= 1'b0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
        end else if (pend_close_reg) begin
            if (!job_full) begin
                pend_close_reg <= 1'b0;
                count_reg      <= '0;
            end
        end else if (accept) begin
            prev_x_reg <= s_vertex_x;
            prev_y_reg <= s_vertex_y;
            if (first_vtx) begin
                first_x_reg <= s_vertex_x;
                first_y_reg <= s_vertex_y;
            end
            if (s_last_vertex && first_vtx) begin
                count_reg <= '0;
            end else begin
                count_reg      <= count_next;
                pend_close_reg <= s_last_vertex;
            end
        end
    end

endmodule

/* hdl/pph_back.sv */
// ----------------------------------------------------------------------------
// pph_back
// Works through edge jobs with one shared limb multiplier and an accumulator:
// crossing parity, segment distance test, nearest segment, shape result.
// ----------------------------------------------------------------------------
module pph_back #(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_BITS   = 24,
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1),
    localparam int D_W    = COORD_BITS + 1,
    localparam int JOB_W  = pph_pkg::JOB_FLAGS_W + CNT_W + 8 * D_W
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [pph_pkg::MARGIN_W-1:0]      margin,
    input  logic                              job_empty,
    input  logic [JOB_W-1:0]                  job_data,
    output logic                              job_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_near_edge,
    output logic [pph_pkg::EDGE_INDEX_W-1:0]  m_edge_index,
    output logic                              m_inside_res,
    output logic                              m_hit
);
    import pph_pkg::*;

    localparam int LW    = (D_W > MARGIN_W) ? D_W : MARGIN_W;
    localparam int MAG_W = 6 * LW;
    localparam int ACC_W = MAG_W + 1;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // Product steps.
    localparam logic [3:0] OP_C0 = 4'd0;   // crossing left product
    localparam logic [3:0] OP_C1 = 4'd1;   // crossing right product, subtracted
    localparam logic [3:0] OP_L0 = 4'd2;   // dx squared
    localparam logic [3:0] OP_L1 = 4'd3;   // dy squared
    localparam logic [3:0] OP_D0 = 4'd4;   // ux times dx
    localparam logic [3:0] OP_D1 = 4'd5;   // uy times dy
    localparam logic [3:0] OP_X0 = 4'd6;   // ux times dy
    localparam logic [3:0] OP_X1 = 4'd7;   // uy times dx, subtracted
    localparam logic [3:0] OP_M  = 4'd8;   // margin squared
    localparam logic [3:0] OP_S  = 4'd9;   // cross squared
    localparam logic [3:0] OP_R  = 4'd10;  // margin squared times length squared
    localparam logic [3:0] OP_T  = 4'd11;  // cross squared times best length
    localparam logic [3:0] OP_U  = 4'd12;  // best cross squared times length

    logic [2:0]          state_reg;
    logic [3:0]          op_reg;
    logic [1:0]          i_reg;
    logic                j_reg;
    logic [JOB_W-1:0]    job_reg;
    logic [2*LW-1:0]     prod_reg;
    logic [2:0]          pshift_reg;
    logic                pneg_reg;
    logic                pvalid_reg;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [2*LW-1:0]     len2_reg, ca_reg, m2_reg, best_len_reg;
    logic [4*LW-1:0]     ca2_reg, best_ca2_reg;
    logic [MAG_W-1:0]    t_reg;
    logic                parity_reg;
    logic                best_valid_reg;
    logic [CNT_W-1:0]    best_idx_reg;
    logic                m_valid_reg;
    logic                near_reg, inside_reg, hit_reg;
    logic [EDGE_INDEX_W-1:0] index_reg;

    job_flags_t          flags;
    logic [CNT_W-1:0]    job_seg;
    logic signed [D_W-1:0] diff [8];
    logic [4*LW-1:0]     a_vec;
    logic [2*LW-1:0]     b_vec;
    logic                op_neg;
    logic [1:0]          na_m1;
    logic                nb_m1;
    logic [LW-1:0]       a_limb, b_limb;
    logic [ACC_W-1:0]    term;
    logic                acc_neg;
    logic [MAG_W-1:0]    acc_mag;
    logic                out_free;
    logic [CNT_W+EDGE_INDEX_W-1:0] idx_ext;

    // Magnitude of a coordinate difference.
    function automatic logic [LW-1:0] mag(input logic signed [D_W-1:0] d);
        logic [D_W-1:0] n;
        n = d[D_W-1] ? -d : d;
        return LW'(n);
    endfunction

    // Job fields.
    assign flags   = job_flags_t'(job_reg[JOB_W-1 -: JOB_FLAGS_W]);
    assign job_seg = job_reg[8*D_W +: CNT_W];
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            diff[k] = job_reg[k*D_W +: D_W];
        end
    end

    // Operand selection for the current step; indexes: 0 dx, 1 dy, 2 ux,
    // 3 uy, 4 cy1, 5 cdx, 6 cdy, 7 cx1.
    always_comb begin
        a_vec  = '0;
        b_vec  = '0;
        op_neg = 1'b0;
        na_m1  = 2'd0;
        nb_m1  = 1'b0;
        unique case (op_reg)
            OP_C0: begin
                a_vec  = (4*LW)'(mag(diff[4]));
                b_vec  = (2*LW)'(mag(diff[5]));
                op_neg = diff[4][D_W-1] ^ diff[5][D_W-1];
            end
            OP_C1: begin
                a_vec  = (4*LW)'(mag(diff[6]));
                b_vec  = (2*LW)'(mag(diff[7]));
                op_neg = !(diff[6][D_W-1] ^ diff[7][D_W-1]);
            end
            OP_L0: begin
                a_vec = (4*LW)'(mag(diff[0]));
                b_vec = (2*LW)'(mag(diff[0]));
            end
            OP_L1: begin
                a_vec = (4*LW)'(mag(diff[1]));
                b_vec = (2*LW)'(mag(diff[1]));
            end
            OP_D0: begin
                a_vec  = (4*LW)'(mag(diff[2]));
                b_vec  = (2*LW)'(mag(diff[0]));
                op_neg = diff[2][D_W-1] ^ diff[0][D_W-1];
            end
            OP_D1: begin
                a_vec  = (4*LW)'(mag(diff[3]));
                b_vec  = (2*LW)'(mag(diff[1]));
                op_neg = diff[3][D_W-1] ^ diff[1][D_W-1];
            end
            OP_X0: begin
                a_vec  = (4*LW)'(mag(diff[2]));
                b_vec  = (2*LW)'(mag(diff[1]));
                op_neg = diff[2][D_W-1] ^ diff[1][D_W-1];
            end
            OP_X1: begin
                a_vec  = (4*LW)'(mag(diff[3]));
                b_vec  = (2*LW)'(mag(diff[0]));
                op_neg = !(diff[3][D_W-1] ^ diff[0][D_W-1]);
            end
            OP_M: begin
                a_vec = (4*LW)'(margin);
                b_vec = (2*LW)'(margin);
            end
            OP_S: begin
                a_vec = (4*LW)'(ca_reg);
                b_vec = ca_reg;
                na_m1 = 2'd1;
                nb_m1 = 1'b1;
            end
            OP_R: begin
                a_vec = (4*LW)'(m2_reg);
                b_vec = len2_reg;
                na_m1 = 2'd1;
                nb_m1 = 1'b1;
            end
            OP_T: begin
                a_vec = ca2_reg;
                b_vec = best_len_reg;
                na_m1 = 2'd3;
                nb_m1 = 1'b1;
            end
            OP_U: begin
                a_vec = best_ca2_reg;
                b_vec = len2_reg;
                na_m1 = 2'd3;
                nb_m1 = 1'b1;
            end
            default: ;
        endcase
    end

    assign a_limb = a_vec[i_reg*LW +: LW];
    assign b_limb = b_vec[j_reg*LW +: LW];

    // Accumulator: the registered product is added at its limb offset.
    always_comb begin
        term = ACC_W'(prod_reg) << (LW * pshift_reg);
        acc_next = acc_reg;
        if (pvalid_reg) begin
            acc_next = pneg_reg ? acc_reg - term : acc_reg + term;
        end
    end

    assign acc_neg  = acc_reg[ACC_W-1];
    assign acc_mag  = acc_neg ? MAG_W'(-acc_reg) : acc_reg[MAG_W-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign job_pop  = (state_reg == ST_IDLE) && !job_empty;
    assign idx_ext  = {{EDGE_INDEX_W{1'b0}}, best_idx_reg};

    // Multiplier stage.
    always_ff @(posedge aclk) begin
        prod_reg   <= a_limb * b_limb;
        pshift_reg <= {1'b0, i_reg} + {2'b00, j_reg};
        pneg_reg   <= op_neg;
    end

    // Job sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_C0;
            i_reg          <= '0;
            j_reg          <= 1'b0;
            pvalid_reg     <= 1'b0;
            parity_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
            best_idx_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pvalid_reg <= (state_reg == ST_RUN);
            acc_reg    <= acc_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!job_empty) begin
                        job_reg   <= job_data;
                        op_reg    <= OP_C0;
                        i_reg     <= '0;
                        j_reg     <= 1'b0;
                        acc_reg   <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (j_reg == nb_m1) begin
                        j_reg <= 1'b0;
                        if (i_reg == na_m1) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end else begin
                        j_reg <= 1'b1;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    i_reg     <= '0;
                    j_reg     <= 1'b0;
                    state_reg <= ST_RUN;
                    unique case (op_reg)
                        OP_C0: op_reg <= OP_C1;
                        OP_C1: begin
                            if (flags.cross_pre && acc_neg) begin
                                parity_reg <= !parity_reg;
                            end
                            acc_reg <= '0;
                            if (flags.seg_ok) begin
                                op_reg <= OP_L0;
                            end else begin
                                state_reg <= ST_FIN;
                            end
                        end
                        OP_L0: op_reg <= OP_L1;
                        OP_L1: begin
                            len2_reg <= acc_reg[2*LW-1:0];
                            acc_reg  <= '0;
                            op_reg   <= OP_D0;
                        end
                        OP_D0: op_reg <= OP_D1;
                        OP_D1: begin
                            acc_reg <= '0;
                            // Foot of the perpendicular off the segment, or
                            // a segment of zero length.
                            if (len2_reg == '0 || acc_neg ||
                                acc_reg[MAG_W-1:0] > MAG_W'(len2_reg)) begin
                                state_reg <= ST_FIN;
                            end else begin
                                op_reg <= OP_X0;
                            end
                        end
                        OP_X0: op_reg <= OP_X1;
                        OP_X1: begin
                            ca_reg  <= acc_mag[2*LW-1:0];
                            acc_reg <= '0;
                            op_reg  <= OP_M;
                        end
                        OP_M: begin
                            m2_reg  <= acc_reg[2*LW-1:0];
                            acc_reg <= '0;
                            op_reg  <= OP_S;
                        end
                        OP_S: begin
                            ca2_reg <= acc_reg[4*LW-1:0];
                            acc_reg <= '0;
                            op_reg  <= OP_R;
                        end
                        OP_R: begin
                            acc_reg <= '0;
                            if (MAG_W'(ca2_reg) > acc_reg[MAG_W-1:0]) begin
                                state_reg <= ST_FIN;
                            end else if (best_valid_reg) begin
                                op_reg <= OP_T;
                            end else begin
                                best_valid_reg <= 1'b1;
                                best_idx_reg   <= job_seg;
                                best_ca2_reg   <= ca2_reg;
                                best_len_reg   <= len2_reg;
                                state_reg      <= ST_FIN;
                            end
                        end
                        OP_T: begin
                            t_reg   <= acc_reg[MAG_W-1:0];
                            acc_reg <= '0;
                            op_reg  <= OP_U;
                        end
                        OP_U: begin
                            // Only a strictly nearer segment replaces the best.
                            if (t_reg < acc_reg[MAG_W-1:0]) begin
                                best_idx_reg <= job_seg;
                                best_ca2_reg <= ca2_reg;
                                best_len_reg <= len2_reg;
                            end
                            state_reg <= ST_FIN;
                        end
                        default: state_reg <= ST_FIN;
                    endcase
                end
                ST_FIN: begin
                    if (!flags.emit) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        parity_reg     <= 1'b0;
                        best_valid_reg <= 1'b0;
                        best_idx_reg   <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && flags.emit && out_free) begin
            near_reg   <= best_valid_reg;
            index_reg  <= best_valid_reg ? idx_ext[EDGE_INDEX_W-1:0] : '0;
            inside_reg <= flags.inside_en && parity_reg;
            hit_reg    <= best_valid_reg || (flags.inside_en && parity_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_near_edge  = near_reg;
    assign m_edge_index = index_reg;
    assign m_inside_res = inside_reg;
    assign m_hit        = hit_reg;

endmodule

/* hdl/pph_checker.sv */
// ----------------------------------------------------------------------------
// pph_checker
// Port-level checks of the result channel of the hit test block.
// ----------------------------------------------------------------------------
module pph_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_near_edge,
    input logic [pph_pkg::EDGE_INDEX_W-1:0]  m_edge_index,
    input logic                              m_inside_res,
    input logic                              m_hit
);
    import pph_pkg::*;

    // A waiting result item holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_edge_index) && $stable(m_hit))
        else $error("result item dropped or changed while stalled");

    // No result item is shown right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hit is the union of the near and inside outcomes.
    a_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit == (m_near_edge || m_inside_res)))
        else $error("hit does not match near and inside");

    // Without a near segment the index reads zero.
    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_near_edge |-> (m_edge_index == '0))
        else $error("edge index set without a near segment");

endmodule

bind polygon_point_hit_test pph_checker u_pph_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_near_edge  (m_near_edge),
    .m_edge_index (m_edge_index),
    .m_inside_res (m_inside_res),
    .m_hit        (m_hit)
);
